[rtl/core/mwpo_pkg.sv]
`timescale 1ns / 1ps
package mwpo_pkg;

  localparam int PHASE_BITS_DEF      = 32;
  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam int SAMPLE_W   = 16;
  localparam int FREQ_W     = 30;
  localparam int GATE_W     = 16;
  localparam int PERIOD_W   = 32;
  localparam int SINE_VAL_W = 15;
  localparam int PADDR_W    = 3;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd97391;
  localparam logic [63:0]         HALF_PI_Q30  = 64'd1686629713;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_SAW      = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } wave_t;

  typedef enum logic {
    REG_WAVEFORM      = 1'b0,
    REG_SAMPLE_PERIOD = 1'b1
  } reg_idx_t;

  // divisor of the n-th odd Taylor term: (2n)(2n+1)
  function automatic logic [63:0] taylor_div(int unsigned n);
    logic [63:0] d;
    case (n)
      1:       d = 64'd6;
      2:       d = 64'd20;
      3:       d = 64'd42;
      4:       d = 64'd72;
      5:       d = 64'd110;
      default: d = 64'd156;
    endcase
    return d;
  endfunction

  // restoring shift-and-subtract quotient, truncated toward zero
  function automatic logic [63:0] long_div(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // quarter-wave sine entry k, Q1.15 magnitude saturated to 32767
  function automatic logic [SINE_VAL_W-1:0] sine_entry(int unsigned k, int unsigned tb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    x    = (64'(k) * HALF_PI_Q30) >> tb;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int unsigned n = 1; n <= 6; n++) begin
      term = long_div((term * x2) >> 30, taylor_div(n));
      if ((n & 1) != 0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = (sum + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SINE_VAL_W-1:0];
  endfunction

endpackage

[rtl/core/mwpo_sine_rom.sv]
`timescale 1ns / 1ps
module mwpo_sine_rom #(
  parameter int SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rd_en,
  input  logic [SINE_TABLE_BITS:0]        rd_addr,
  output logic [mwpo_pkg::SINE_VAL_W-1:0] rd_data
);
  import mwpo_pkg::*;

  localparam int DEPTH = (1 << SINE_TABLE_BITS) + 1;

  logic [SINE_VAL_W-1:0] rom_words [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_word
    localparam logic [SINE_VAL_W-1:0] WORD = sine_entry(g, SINE_TABLE_BITS);
    assign rom_words[g] = WORD;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= rom_words[rd_addr];
    end
  end

endmodule

[rtl/core/multi_waveform_phase_oscillator_top.sv]
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// in        input      in_valid / in_stall    freq_control[29:0], gate_level[15:0]
// out       output     out_valid / out_stall  sample[15:0] (signed Q1.15)
// config    input      APB write/read         waveform @0x0, sample_period @0x4
//
// The sine ROM is read at acceptance; three products then run on the single
// 32x32 multiplier (freq*gate, then its low and high halves against
// sample_period), and a final add step adds the increment to the phase and
// loads the result. in_stall stays high from acceptance until the result is
// loaded; a stalled output holds the next result back and keeps in_stall high.
// Reset (synchronous, rst high) clears phase and the pending result and
// restores waveform and sample_period to their defaults.
module multi_waveform_phase_oscillator_top #(
  parameter int PHASE_BITS      = mwpo_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mwpo_pkg::FREQ_W-1:0]          freq_control,
  input  logic [mwpo_pkg::GATE_W-1:0]          gate_level,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mwpo_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [mwpo_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import mwpo_pkg::*;

  localparam logic [SINE_TABLE_BITS:0] QTR_SIZE =
    (SINE_TABLE_BITS + 1)'(1) << SINE_TABLE_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_ADD,
    ST_HOLD
  } state_t;

  state_t state;

  // configuration
  wave_t                 waveform;
  logic [PERIOD_W-1:0]   sample_period;
  logic                  cfg_wr;
  reg_idx_t              cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform      <= WAVE_SINE;
      sample_period <= PERIOD_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WAVEFORM:      waveform      <= wave_t'(pwdata[1:0]);
        REG_SAMPLE_PERIOD: sample_period <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WAVEFORM:      prdata = {30'd0, waveform};
      REG_SAMPLE_PERIOD: prdata = sample_period;
      default:           prdata = 32'd0;
    endcase
  end

  // datapath registers
  logic [PHASE_BITS-1:0] phase;
  logic [FREQ_W-1:0]     freq_q;
  logic [GATE_W-1:0]     gate_q;
  logic [63:0]           prod;
  logic [13:0]           a_hi;
  logic [62:0]           acc;
  logic [SAMPLE_W-1:0]   res;

  logic in_take;
  logic out_free;
  logic out_load;
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign out_load = (state inside {ST_ADD, ST_HOLD}) && out_free;

  // phase viewed as a 48-bit fraction
  logic [47:0]                ph48;
  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] k_idx;
  logic [SINE_TABLE_BITS:0]   rom_addr;
  logic [SINE_VAL_W-1:0]      rom_q;

  assign ph48     = 48'(phase) << (48 - PHASE_BITS);
  assign quad     = ph48[47:46];
  assign k_idx    = ph48[45 -: SINE_TABLE_BITS];
  assign rom_addr = quad[0] ? (QTR_SIZE - {1'b0, k_idx}) : {1'b0, k_idx};

  mwpo_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk    (clk),
    .rd_en  (in_take),
    .rd_addr(rom_addr),
    .rd_data(rom_q)
  );

  // shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  always_comb begin
    case (state)
      ST_MUL0: begin
        mul_a = {2'd0, freq_q};
        mul_b = {16'd0, gate_q};
      end
      ST_MUL1: begin
        mul_a = prod[31:0];
        mul_b = sample_period;
      end
      default: begin
        mul_a = {18'd0, a_hi};
        mul_b = sample_period;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // increment keeps product bits [62 : 63-PHASE_BITS]
  logic [62:0]           sum63;
  logic [PHASE_BITS-1:0] incr;
  logic [PHASE_BITS-1:0] phase_next;

  assign sum63      = acc + {prod[30:0], 32'd0};
  assign incr       = sum63[62 -: PHASE_BITS];
  assign phase_next = phase + incr;

  // waveform at the phase before the advance
  logic [47:0]         mirror;
  logic [SAMPLE_W-1:0] shape;

  assign mirror = 48'd0 - ph48;

  always_comb begin
    case (waveform)
      WAVE_SINE: begin
        shape = quad[1] ? (16'd0 - {1'b0, rom_q}) : {1'b0, rom_q};
      end
      WAVE_SQUARE: begin
        shape = ph48[47] ? 16'h7fff : 16'h8000;
      end
      WAVE_SAW: begin
        shape = {~ph48[47], ph48[46:32]};
      end
      WAVE_TRIANGLE: begin
        if (!ph48[47]) begin
          shape = {~ph48[46], ph48[45:31]};
        end else if (mirror[47]) begin
          shape = 16'h7fff;
        end else begin
          shape = {~mirror[46], mirror[45:31]};
        end
      end
      default: shape = 16'h0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      phase     <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            freq_q <= freq_control;
            gate_q <= gate_level;
            state  <= ST_MUL0;
          end
        end
        ST_MUL0: begin
          prod  <= mul_p;
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          a_hi  <= prod[45:32];
          prod  <= mul_p;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          acc   <= prod[62:0];
          prod  <= mul_p;
          state <= ST_ADD;
        end
        ST_ADD: begin
          phase <= phase_next;
          if (out_free) begin
            sample <= shape;
            state  <= ST_IDLE;
          end else begin
            res   <= shape;
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            sample <= res;
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/mwpo_checker.sv]
`timescale 1ns / 1ps
module mwpo_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [mwpo_pkg::SAMPLE_W-1:0] sample
);
  import mwpo_pkg::*;

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // a request keeps the input side busy through the multiply sequence
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall ##1 in_stall ##1 in_stall)
    else $error("input ready again before the sequence finished");

  // a new result never appears while the input side is idle without a request
  a_result_needs_work: assert property (@(posedge clk) disable iff (rst)
    (!in_stall && !out_valid) |=> !out_valid)
    else $error("result produced with no request in flight");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(sample)))
    else $error("stalled result changed");

endmodule

bind multi_waveform_phase_oscillator_top mwpo_checker u_mwpo_checker (.*);

[test/osc_checker.sv]
`timescale 1ns / 1ps
module osc_checker
  import mwpo_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [FREQ_W-1:0]          freq_control,
  input  logic [GATE_W-1:0]          gate_level,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [31:0]                pwdata,
  output int                         mismatches,
  output int                         waiting
);

  localparam int TBL_BITS = SINE_TABLE_BITS_DEF;
  localparam int QTR      = 1 << TBL_BITS;

  logic [14:0]                quarter_mag [0:QTR];
  logic signed [SAMPLE_W-1:0] sample_due [$];
  logic signed [SAMPLE_W-1:0] want;
  logic [31:0]                phase_acc;
  logic [PERIOD_W-1:0]        period_sel;
  wave_t                      wave_sel;

  // sin(x) on [0, pi/2] in Q30, odd series terms up to x^13
  function automatic logic [14:0] quarter_sine(int unsigned k);
    logic [63:0] ang;
    logic [63:0] ang_sq;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] mag;
    ang    = (64'(k) * 64'd1686629713) >> TBL_BITS;
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    acc    = ang;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    mag = (acc + 64'd16384) >> 15;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return mag[14:0];
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] osc_sample(wave_t w, logic [31:0] ph);
    int unsigned k;
    int          v;
    logic [32:0] rest;
    case (w)
      WAVE_SINE: begin
        k = (ph >> (30 - TBL_BITS)) & (QTR - 1);
        // odd quadrants run the table backwards, upper half is negative
        if (ph[30]) begin
          k = QTR - k;
        end
        v = int'(quarter_mag[k]);
        if (ph[31]) begin
          v = -v;
        end
      end
      WAVE_SQUARE: v = ph[31] ? 32767 : -32768;
      WAVE_SAW:    v = int'(ph[31:16]) - 32768;
      default: begin
        if (!ph[31]) begin
          v = int'(ph[30:15]) - 32768;
        end else begin
          rest = 33'h1_0000_0000 - 33'(ph);
          v    = int'(rest >> 15) - 32768;
          if (v > 32767) begin
            v = 32767;
          end
        end
      end
    endcase
    return 16'(v);
  endfunction

  // freq * gate * period carries 63 fraction bits; keep 32 of them
  function automatic logic [31:0] phase_step(logic [FREQ_W-1:0] f, logic [GATE_W-1:0] g,
                                             logic [PERIOD_W-1:0] p);
    logic [127:0] prod;
    prod = 128'(f) * 128'(g) * 128'(p);
    return prod[62:31];
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) begin
      $display("checker @%0t: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    waiting    = 0;
    for (int k = 0; k <= QTR; k++) begin
      quarter_mag[k] = quarter_sine(k);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      phase_acc  = '0;
      wave_sel   = WAVE_SINE;
      period_sel = PERIOD_RESET;
      sample_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_WAVEFORM, 2'b00}) begin
          wave_sel = wave_t'(pwdata[1:0]);
        end else if (paddr == {REG_SAMPLE_PERIOD, 2'b00}) begin
          period_sel = pwdata;
        end
      end
      if (in_valid && !in_stall) begin
        sample_due = {sample_due, osc_sample(wave_sel, phase_acc)};
        phase_acc  = phase_acc + phase_step(freq_control, gate_level, period_sel);
      end
      if (out_valid && !out_stall) begin
        if (sample_due.size() == 0) begin
          report_mismatch($sformatf("sample %0d with no request pending", sample));
        end else begin
          want = sample_due.pop_front();
          if (sample !== want) begin
            report_mismatch($sformatf("sample %0d, expected %0d", sample, want));
          end
        end
      end
    end
    waiting = sample_due.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;
  import mwpo_pkg::*;

  logic                       clk;
  logic                       rst          = 1'b1;
  logic                       in_valid     = 1'b0;
  logic                       in_stall;
  logic [FREQ_W-1:0]          freq_control = '0;
  logic [GATE_W-1:0]          gate_level   = '0;
  logic                       out_valid;
  logic                       out_stall    = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       psel         = 1'b0;
  logic                       penable      = 1'b0;
  logic                       pwrite       = 1'b0;
  logic [PADDR_W-1:0]         paddr        = '0;
  logic [31:0]                pwdata       = '0;
  logic [31:0]                prdata;
  logic                       pready;

  int   mismatches;
  int   waiting;
  logic calm     = 1'b0;
  logic hold_out = 1'b0;

  multi_waveform_phase_oscillator_top DUT (
    .clk, .rst, .in_valid, .in_stall, .freq_control, .gate_level,
    .out_valid, .out_stall, .sample,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  osc_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .freq_control, .gate_level,
    .out_valid, .out_stall, .sample,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .mismatches, .waiting
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 32);
      end
    end
  end

  task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_tone(input logic [FREQ_W-1:0] f, input logic [GATE_W-1:0] g);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    freq_control <= f;
    gate_level   <= g;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and wait out every pending sample
  task automatic settle(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (waiting == 0);
    repeat (tail) @(posedge clk);
  endtask

  function automatic logic [FREQ_W-1:0] rand_freq();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return FREQ_W'($urandom) >> $urandom_range(FREQ_W - 1);
    endcase
  endfunction

  function automatic logic [GATE_W-1:0] rand_gate();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 16'd32768;
      2:       return 16'hFFFF;
      3:       return GATE_W'($urandom_range(65535, 32769));
      default: return GATE_W'($urandom_range(32768));
    endcase
  endfunction

  initial begin
    wave_t       w;
    logic [31:0] period;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings; zero frequency or zero gate leaves phase at zero
    send_tone('0, 16'hFFFF);
    send_tone('1, '0);
    settle(8);

    // half-second period: quarter and half cycle steps land on exact phases
    write_reg(REG_SAMPLE_PERIOD, 32'h8000_0000);
    repeat (4) send_tone(FREQ_W'(32768), 16'd32768);
    settle(8);
    write_reg(REG_WAVEFORM, 32'(WAVE_TRIANGLE));
    repeat (2) send_tone(FREQ_W'(65536), 16'd32768);
    settle(8);
    write_reg(REG_WAVEFORM, 32'(WAVE_SQUARE));
    repeat (2) send_tone(FREQ_W'(65536), 16'd32768);
    settle(8);
    // only the low two bits count: selects the saw
    write_reg(REG_WAVEFORM, 32'hFFFF_FFFE);
    repeat (2) send_tone(FREQ_W'(65536), 16'd32768);
    settle(8);
    write_reg(REG_SAMPLE_PERIOD, 32'hFFFF_FFFF);
    repeat (3) send_tone('1, 16'hFFFF);
    send_tone('1, 16'd32768);
    settle(8);

    for (int p = 0; p < 16; p++) begin
      w = wave_t'(p % 4);
      case (p % 5)
        0:       period = 32'hFFFF_FFFF;
        1:       period = '0;
        2:       period = PERIOD_RESET;
        3:       period = $urandom;
        default: period = $urandom_range(1 << 20, 1);
      endcase
      write_reg(REG_WAVEFORM, 32'(w));
      write_reg(REG_SAMPLE_PERIOD, period);
      calm = (p == 5);
      if (p == 9) begin
        hold_out = 1'b1;
      end
      for (int i = 0; i < 125; i++) begin
        if (p == 12 && i == 60) begin
          settle(0);
        end
        send_tone(rand_freq(), rand_gate());
      end
      settle(8);
    end
    calm = 1'b0;

    settle(20);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
